// ----- sv/stepper_axis_travel_measure_top_macros.svh -----
// Assertion helpers used by the core RTL file (stam_core).
`ifndef STEPPER_AXIS_TRAVEL_MEASURE_TOP_MACROS_SVH
`define STEPPER_AXIS_TRAVEL_MEASURE_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define STAM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define STAM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/stam_pkg.sv -----
`default_nettype none
package stam_pkg;

   localparam int SEARCH_W = 18;
   localparam int TRAVEL_W = 19;
   localparam int CSR_DATA_W = 19;

   localparam logic [SEARCH_W-1:0] SEARCH_LIMIT_RESET = 18'd200000;
   localparam logic [TRAVEL_W-1:0] TRAVEL_LIMIT_RESET = 19'd400000;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SEARCH = 2'd1,
      PH_TRAVEL = 2'd2
   } phase_type;

   typedef enum logic [0:0] {
      CSR_SEARCH_LIMIT = 1'b0,
      CSR_TRAVEL_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SW_NONE = 2'd0,
      SW_X    = 2'd1,
      SW_Y    = 2'd2,
      SW_Z    = 2'd3
   } switch_id_type;

   typedef enum logic [0:0] {
      CMD_TICK  = 1'b0,
      CMD_START = 1'b1
   } command_type;

   localparam logic [1:0] AXIS_INVALID = 2'd3;

   typedef struct packed {
      logic       command;
      logic [1:0] axis_select;
      logic       switch_x;
      logic       switch_y;
      logic       switch_z;
   } req_item_type;

   typedef struct packed {
      logic                step_now;
      logic                direction;
      logic [1:0]          axis_out;
      logic                busy_res;
      logic                done_res;
      logic                failed;
      logic [TRAVEL_W-1:0] travel_steps;
   } rsp_item_type;

   // Exactly one pressed switch names it, anything else is none.
   function automatic switch_id_type switch_id(input logic x, input logic y, input logic z);
      switch_id_type id;
      id = SW_NONE;
      if (x && !y && !z) id = SW_X;
      else if (!x && y && !z) id = SW_Y;
      else if (!x && !y && z) id = SW_Z;
      return id;
   endfunction

endpackage
`default_nettype wire

// ----- sv/stam_ifs.sv -----
`default_nettype none
interface stam_req_if;
   import stam_pkg::*;
   logic       valid;
   logic       ready;
   logic       command;
   logic [1:0] axis_select;
   logic       switch_x;
   logic       switch_y;
   logic       switch_z;

   modport source (output valid, command, axis_select, switch_x, switch_y, switch_z,
                   input ready);
   modport sink (input valid, command, axis_select, switch_x, switch_y, switch_z,
                 output ready);
endinterface

interface stam_rsp_if;
   import stam_pkg::*;
   logic                valid;
   logic                ready;
   logic                step_now;
   logic                direction;
   logic [1:0]          axis_out;
   logic                busy_res;
   logic                done_res;
   logic                failed;
   logic [TRAVEL_W-1:0] travel_steps;

   modport source (output valid, step_now, direction, axis_out, busy_res, done_res,
                   failed, travel_steps, input ready);
   modport sink (input valid, step_now, direction, axis_out, busy_res, done_res,
                 failed, travel_steps, output ready);
endinterface
`default_nettype wire

// ----- sv/stam_in_reg.sv -----
`default_nettype none
module stam_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   stam_req_if.sink                   req_chan,
   output logic                       item_valid,
   output stam_pkg::req_item_type     item,
   input  wire logic                  item_ready
);
   import stam_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_chan.ready = !valid_ff || item_ready;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.command     <= req_chan.command;
         item_ff.axis_select <= req_chan.axis_select;
         item_ff.switch_x    <= req_chan.switch_x;
         item_ff.switch_y    <= req_chan.switch_y;
         item_ff.switch_z    <= req_chan.switch_z;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule
`default_nettype wire

// ----- sv/stam_core.sv -----
`default_nettype none
`include "stepper_axis_travel_measure_top_macros.svh"
module stam_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [0:0]                      csr_index,
   input  wire logic [stam_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            item_valid,
   input  wire stam_pkg::req_item_type          item,
   output logic                                 item_ready,
   stam_rsp_if.source                           rsp_chan
);
   import stam_pkg::*;

   logic [SEARCH_W-1:0] search_limit_ff;
   logic [TRAVEL_W-1:0] travel_limit_ff;

   phase_type           phase_ff, phase_in;
   logic                dir_ff, dir_in;
   logic [1:0]          axis_ff, axis_in;
   switch_id_type       start_ff, start_in;
   logic [SEARCH_W-1:0] search_ff, search_in;
   logic [TRAVEL_W-1:0] travel_ff, travel_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;
   logic                advance;

   assign item_ready = !rsp_valid_ff || rsp_chan.ready;
   assign advance = item_valid && item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_limit_ff <= SEARCH_LIMIT_RESET;
         travel_limit_ff <= TRAVEL_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEARCH_LIMIT: search_limit_ff <= csr_wdata[SEARCH_W-1:0];
            CSR_TRAVEL_LIMIT: travel_limit_ff <= csr_wdata[TRAVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      switch_id_type id;
      logic          go_travel;
      logic          step, busy, done, fail;
      logic [TRAVEL_W-1:0] count;

      id = switch_id(item.switch_x, item.switch_y, item.switch_z);
      go_travel = 1'b0;
      step = 1'b0;
      busy = 1'b0;
      done = 1'b0;
      fail = 1'b0;
      count = '0;
      phase_in = phase_ff;
      dir_in = dir_ff;
      axis_in = axis_ff;
      start_in = start_ff;
      search_in = search_ff;
      travel_in = travel_ff;

      if (item.command == CMD_START) begin
         if (item.axis_select == AXIS_INVALID) begin
            phase_in = PH_IDLE;
            done = 1'b1;
            fail = 1'b1;
         end else begin
            axis_in = item.axis_select;
            search_in = '0;
            travel_in = '0;
            start_in = id;
            if (id != SW_NONE) begin
               go_travel = 1'b1;
            end else if (search_limit_ff == '0) begin
               phase_in = PH_IDLE;
               done = 1'b1;
               fail = 1'b1;
            end else begin
               phase_in = PH_SEARCH;
               search_in = SEARCH_W'(1);
               step = 1'b1;
               busy = 1'b1;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (id != SW_NONE) begin
                  start_in = id;
                  dir_in = !dir_ff;
                  go_travel = 1'b1;
               end else if (search_ff >= search_limit_ff) begin
                  phase_in = PH_IDLE;
                  done = 1'b1;
                  fail = 1'b1;
               end else begin
                  search_in = search_ff + SEARCH_W'(1);
                  step = 1'b1;
                  busy = 1'b1;
               end
            end
            PH_TRAVEL: begin
               if (id != SW_NONE && id != start_ff) begin
                  dir_in = !dir_ff;
                  phase_in = PH_IDLE;
                  done = 1'b1;
                  count = travel_ff;
               end else if (travel_ff >= travel_limit_ff) begin
                  phase_in = PH_IDLE;
                  done = 1'b1;
                  fail = 1'b1;
               end else begin
                  travel_in = travel_ff + TRAVEL_W'(1);
                  step = 1'b1;
                  busy = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      // Entering travel: the first travel step goes out with this request, unless the travel limit is zero.
      if (go_travel) begin
         travel_in = '0;
         if (travel_limit_ff == '0) begin
            phase_in = PH_IDLE;
            done = 1'b1;
            fail = 1'b1;
         end else begin
            phase_in = PH_TRAVEL;
            travel_in = TRAVEL_W'(1);
            step = 1'b1;
            busy = 1'b1;
         end
      end

      rsp_in.step_now = step;
      rsp_in.direction = dir_in;
      rsp_in.axis_out = axis_in;
      rsp_in.busy_res = busy;
      rsp_in.done_res = done;
      rsp_in.failed = fail;
      rsp_in.travel_steps = count;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         dir_ff <= 1'b1;
         axis_ff <= '0;
         start_ff <= SW_NONE;
         search_ff <= '0;
         travel_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            dir_ff <= dir_in;
            axis_ff <= axis_in;
            start_ff <= start_in;
            search_ff <= search_in;
            travel_ff <= travel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.step_now = rsp_ff.step_now;
   assign rsp_chan.direction = rsp_ff.direction;
   assign rsp_chan.axis_out = rsp_ff.axis_out;
   assign rsp_chan.busy_res = rsp_ff.busy_res;
   assign rsp_chan.done_res = rsp_ff.done_res;
   assign rsp_chan.failed = rsp_ff.failed;
   assign rsp_chan.travel_steps = rsp_ff.travel_steps;

   `STAM_ASSERT_NOW(a_search_count_live, phase_ff == PH_SEARCH, search_ff != '0, "search phase with zero count")
   `STAM_ASSERT_NOW(a_travel_state_live, phase_ff == PH_TRAVEL, travel_ff != '0 && start_ff != SW_NONE, "travel phase without count or start switch")
   `STAM_ASSERT_NOW(a_step_means_busy, rsp_valid_ff && rsp_ff.step_now, rsp_ff.busy_res && !rsp_ff.done_res, "step issued outside a running measurement")
   `STAM_ASSERT_NOW(a_count_only_on_pass, rsp_valid_ff && rsp_ff.travel_steps != '0, rsp_ff.done_res && !rsp_ff.failed, "travel count on a request that is not a pass")
   `STAM_ASSERT_NEXT(a_dir_holds, !advance, $stable(dir_ff) && $stable(phase_ff), "run state moved without a request")

endmodule
`default_nettype wire

// ----- sv/stepper_axis_travel_measure_top.sv -----
`default_nettype none
// Stepper axis travel measurement. A start request picks an axis and samples the three limit
// switches; the block then issues one step per tick request, searching for a switch and then
// counting steps until a different switch closes, and reports the count with done (or failed
// on a limit or invalid axis). Each request yields exactly one response; the request is held
// in the input register and the response in the response register. With rsp ready held high
// a new request is taken every cycle, the pace being set by the single decision stage between
// the request register and the response register. Step limits are to be written by the user
// over the csr port while no request is in flight; the block itself does not enforce this.
module stepper_axis_travel_measure_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   stam_req_if.sink                             req_chan,
   stam_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [0:0]                      csr_index,
   input  wire logic [stam_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import stam_pkg::*;

   logic         item_valid;
   logic         item_ready;
   req_item_type item;

   stam_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   stam_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire
